>>> sv/bks_pkg.sv
// ----------------------------------------------------------------------------
// bks_pkg
// shared widths, operation and status codes and the cell command type for
// the bounded key set
// ----------------------------------------------------------------------------
package bks_pkg;

    localparam int KEY_W    = 8;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 4;

    // request operations; the spare code behaves as a lookup
    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_LOOKUP = 2'd2,
        KIND_SPARE  = 2'd3
    } t_kind;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 3'd0,
        ST_FULL    = 3'd1,
        ST_PRESENT = 3'd2,
        ST_EMPTY   = 3'd3,
        ST_ABSENT  = 3'd4
    } t_status;

    // command broadcast to every cell of the chain
    typedef struct packed {
        logic             ins;
        logic             rem;
        logic [KEY_W-1:0] key;
    } t_cell_cmd;

endpackage

>>> sv/bks_if.sv
// ----------------------------------------------------------------------------
// bks_req_if / bks_rsp_if
// valid/ready channels carrying the request word and the result word
// ----------------------------------------------------------------------------
interface bks_req_if;
    import bks_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  key;

    modport source (output valid, output kind, output key, input ready);
    modport sink   (input valid, input kind, input key, output ready);
endinterface

interface bks_rsp_if;
    import bks_pkg::*;

    logic                valid;
    logic                ready;
    logic                ok;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
    logic                is_full;
    logic                is_empty;

    modport source (output valid, output ok, output status, output count,
                    output is_full, output is_empty, input ready);
    modport sink   (input valid, input ok, input status, input count,
                    input is_full, input is_empty, output ready);
endinterface

>>> sv/bks_cell.sv
// ----------------------------------------------------------------------------
// bks_cell
// one slot of the key chain: holds a key, compares it with the request key,
// ripples the hit flag upwards and takes its upper neighbour's key on removal
// ----------------------------------------------------------------------------
module bks_cell
    import bks_pkg::*;
(
    input  logic             i_clk,
    input  t_cell_cmd        i_cmd,
    input  logic             i_occ,
    input  logic             i_tail,
    input  logic             i_hit_below,
    input  logic [KEY_W-1:0] i_next_key,
    output logic             o_hit_upto,
    output logic [KEY_W-1:0] o_key
);

    logic [KEY_W-1:0] r_key;
    logic [KEY_W-1:0] n_key;
    logic             w_match;

    // compare only while this slot holds a live key
    assign w_match    = i_occ && (r_key == i_cmd.key);
    assign o_hit_upto = i_hit_below | w_match;
    assign o_key      = r_key;

    // append at the tail, or close the gap left by a removed key
    always_comb begin
        n_key = r_key;
        if (i_cmd.ins && i_tail) begin
            n_key = i_cmd.key;
        end else if (i_cmd.rem && o_hit_upto) begin
            n_key = i_next_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule

>>> sv/bounded_key_set.sv
// ----------------------------------------------------------------------------
// bounded_key_set
// fixed-capacity set of 8-bit keys with insert, remove and lookup
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one request word (kind, key); o_rsp returns one result
//   word (ok, status, count, is_full, is_empty) for every request, in order.
//   Both channels move a word when valid and ready are high at a clock edge.
//   Keys live in a chain of CAPACITY cells; all cells compare the key at once
//   and the hit flag ripples along the chain, so a request is decided and the
//   set updated in the cycle it is accepted.
//   The result word appears in the cycle after the request is taken.
//   Throughput: one request per cycle; the output register is the only stage.
//   A request is taken whenever the output register is empty or its word is
//   being taken in the same cycle; while the receiver stalls with a result
//   waiting, i_req.ready stays low and the set does not change.
//   Reset (i_rst_n low, synchronous) empties the set and drops any pending
//   result; no clearing pass is needed since the count alone marks live slots.
//   A remove closes the gap by shifting higher cells down by one.
// ----------------------------------------------------------------------------
module bounded_key_set
    import bks_pkg::*;
#(
    parameter int CAPACITY = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bks_req_if.sink     i_req,
    bks_rsp_if.source   o_rsp
);

    localparam int UW = $clog2(CAPACITY + 1);

    logic [UW-1:0]    r_used;
    logic [UW-1:0]    n_used;
    logic             r_out_valid;
    logic             r_ok;
    t_status          r_status;
    logic [UW-1:0]    r_count;

    logic             w_accept;
    logic             w_full;
    logic             w_empty;
    logic             w_found;
    logic             w_ok;
    t_status          w_status;
    logic             w_do_ins;
    logic             w_do_rem;
    t_cell_cmd        w_cmd;
    logic [UW+COUNT_W-1:0] w_count_wide;

    logic [CAPACITY:0]             w_hit;
    logic [CAPACITY-1:0][KEY_W-1:0] w_keys;

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_full      = (r_used == UW'(CAPACITY));
    assign w_empty     = (r_used == '0);
    assign w_found     = w_hit[CAPACITY];

    // chain of key cells
    assign w_hit[0] = 1'b0;
    generate
        for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic [KEY_W-1:0] w_next;
            if (gi == CAPACITY - 1) begin : g_last
                assign w_next = w_keys[gi];
            end else begin : g_mid
                assign w_next = w_keys[gi+1];
            end
            bks_cell u_cell (
                .i_clk      (i_clk),
                .i_cmd      (w_cmd),
                .i_occ      (UW'(gi) < r_used),
                .i_tail     (UW'(gi) == r_used),
                .i_hit_below(w_hit[gi]),
                .i_next_key (w_next),
                .o_hit_upto (w_hit[gi+1]),
                .o_key      (w_keys[gi])
            );
        end
    endgenerate

    // request decision
    always_comb begin
        w_ok     = 1'b0;
        w_status = ST_DONE;
        w_do_ins = 1'b0;
        w_do_rem = 1'b0;
        case (t_kind'(i_req.kind))
            KIND_INSERT: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else if (w_found) begin
                    w_status = ST_PRESENT;
                end else begin
                    w_ok     = 1'b1;
                    w_do_ins = w_accept;
                end
            end
            KIND_REMOVE: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else if (!w_found) begin
                    w_status = ST_ABSENT;
                end else begin
                    w_ok     = 1'b1;
                    w_do_rem = w_accept;
                end
            end
            default: begin
                if (w_found) begin
                    w_ok = 1'b1;
                end else if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_status = ST_ABSENT;
                end
            end
        endcase
    end

    assign w_cmd.ins = w_do_ins;
    assign w_cmd.rem = w_do_rem;
    assign w_cmd.key = i_req.key;

    // count update
    always_comb begin
        n_used = r_used;
        if (w_do_ins) begin
            n_used = r_used + UW'(1);
        end else if (w_do_rem) begin
            n_used = r_used - UW'(1);
        end
    end

    // count register and result word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_used <= n_used;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_accept) begin
            r_ok     <= w_ok;
            r_status <= w_status;
            r_count  <= n_used;
        end
    end

    // result word outputs
    assign w_count_wide   = {{COUNT_W{1'b0}}, r_count};
    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.ok       = r_ok;
    assign o_rsp.status   = r_status;
    assign o_rsp.count    = w_count_wide[COUNT_W-1:0];
    assign o_rsp.is_full  = (r_count == UW'(CAPACITY));
    assign o_rsp.is_empty = (r_count == '0);

`ifndef SYNTHESIS
    // occupancy never exceeds the capacity
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= UW'(CAPACITY))
        else $error("occupancy above capacity");

    // a successful insert grows the set by one
    a_ins_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_do_ins |=> r_used == $past(r_used) + UW'(1))
        else $error("insert did not grow the set");

    // a refused or lookup request leaves the count alone
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_do_ins && !w_do_rem) |=> $stable(r_used))
        else $error("count changed without insert or remove");

    // a success always reports the done status
    a_ok_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_ok) |-> r_status == ST_DONE)
        else $error("success with a failure status");

    // an insert is never committed for a key already in the set
    a_no_dup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_do_ins |-> !w_found)
        else $error("duplicate key inserted");
`endif

endmodule
